### sv/bbgr_pkg.sv
package bbgr_pkg;

    // Image geometry and framebuffer layout.
    localparam int IMG_WIDTH     = 128;
    localparam int IMG_HEIGHT    = 64;
    localparam int GLYPH_HEIGHT  = 7;
    localparam int GLYPH_WIDTH   = 5;
    localparam int WORD_BITS     = 32;
    localparam int FRAME_WORDS   = IMG_WIDTH * IMG_HEIGHT / WORD_BITS;
    localparam int ADDR_W        = $clog2(FRAME_WORDS);
    localparam int CNT_W         = ADDR_W + 1;
    localparam int MID_ROW       = IMG_HEIGHT / 2;
    localparam int DIGITS        = 10;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BAR_WIDTH = 2'd0;
    localparam logic [1:0] CFG_MAX_VALUE = 2'd1;
    localparam logic [1:0] CFG_MIN_VALUE = 2'd2;

    typedef enum logic [2:0] {
        FN_FILL,
        FN_SET,
        FN_CLEAR,
        FN_TOGGLE,
        FN_READ_PIX,
        FN_GAUGE,
        FN_READ_WORD,
        FN_NONE
    } func_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_PIXRD,
        ST_PIXWR,
        ST_FILL,
        ST_GSETUP,
        ST_GAUGE,
        ST_RESP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic clear_sweep;
        logic fill_sweep;
        logic pix_rd;
        logic pix_wr;
        logic gauge_setup;
        logic gauge_sweep;
        logic out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        func_t func;
        logic  sweep_last;
        logic  gauge_last;
    } dp_status_t;

    // Digit glyphs, seven rows of five pixels, top row in the high bits.
    localparam logic [34:0] GLYPH_ROM [DIGITS] = '{
        {5'h00, 5'h0E, 5'h0A, 5'h0A, 5'h0A, 5'h0E, 5'h00},
        {5'h00, 5'h02, 5'h06, 5'h0A, 5'h02, 5'h02, 5'h00},
        {5'h00, 5'h0C, 5'h02, 5'h06, 5'h08, 5'h0E, 5'h00},
        {5'h00, 5'h0E, 5'h02, 5'h06, 5'h02, 5'h0E, 5'h00},
        {5'h00, 5'h08, 5'h0A, 5'h0E, 5'h02, 5'h02, 5'h00},
        {5'h00, 5'h0E, 5'h08, 5'h0E, 5'h02, 5'h0E, 5'h00},
        {5'h00, 5'h0E, 5'h08, 5'h0E, 5'h0A, 5'h0E, 5'h00},
        {5'h00, 5'h0E, 5'h02, 5'h04, 5'h08, 5'h08, 5'h00},
        {5'h00, 5'h0E, 5'h0A, 5'h0E, 5'h0A, 5'h0E, 5'h00},
        {5'h00, 5'h0E, 5'h0A, 5'h0E, 5'h02, 5'h0E, 5'h00}
    };

    // One glyph row, leftmost pixel in the high bit.
    function automatic logic [4:0] glyph_row(input logic [3:0] digit, input logic [2:0] row);
        logic [34:0] gw;
        logic [4:0]  bits;
        gw = GLYPH_ROM[digit];
        case (row)
            3'd0: bits = gw[34:30];
            3'd1: bits = gw[29:25];
            3'd2: bits = gw[24:20];
            3'd3: bits = gw[19:15];
            3'd4: bits = gw[14:10];
            3'd5: bits = gw[9:5];
            3'd6: bits = gw[4:0];
            default: bits = 5'd0;
        endcase
        return bits;
    endfunction

endpackage

### sv/bbgr_ctrl.sv
module bbgr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  bbgr_pkg::dp_status_t  status,
    output bbgr_pkg::dp_cmd_t     cmd
);
    import bbgr_pkg::*;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    // State and result-valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_sweep = 1'b1;
                if (status.sweep_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (status.func) inside
                    FN_FILL: state_next = ST_FILL;
                    FN_SET, FN_CLEAR, FN_TOGGLE, FN_READ_PIX, FN_READ_WORD:
                        state_next = ST_PIXRD;
                    FN_GAUGE: state_next = ST_GSETUP;
                    default: state_next = ST_RESP;
                endcase
            end
            ST_PIXRD: begin
                cmd.pix_rd = 1'b1;
                state_next = ST_PIXWR;
            end
            ST_PIXWR: begin
                cmd.pix_wr = 1'b1;
                state_next = ST_RESP;
            end
            ST_FILL: begin
                cmd.fill_sweep = 1'b1;
                if (status.sweep_last) state_next = ST_RESP;
            end
            ST_GSETUP: begin
                cmd.gauge_setup = 1'b1;
                state_next      = ST_GAUGE;
            end
            ST_GAUGE: begin
                cmd.gauge_sweep = 1'b1;
                if (status.gauge_last) state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // The result stays valid until its transfer.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

### sv/bbgr_datapath.sv
module bbgr_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bbgr_pkg::dp_cmd_t     cmd,
    output bbgr_pkg::dp_status_t  status,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_wr_index,
    input  logic [6:0]            cfg_wr_data,
    input  logic [2:0]            func,
    input  logic [6:0]            pix_x,
    input  logic [5:0]            pix_y,
    input  logic signed [7:0]     gauge_value,
    input  logic                  fill_bit,
    input  logic [7:0]            word_index,
    output logic                  pixel_bit,
    output logic [31:0]           word_data,
    output logic                  range_error
);
    import bbgr_pkg::*;

    localparam logic signed [8:0] MID_S      = 9'(MID_ROW);
    localparam logic signed [8:0] GH_S       = 9'(GLYPH_HEIGHT);
    localparam logic signed [8:0] LAST_ROW_S = 9'(IMG_HEIGHT - 1);
    // Glyph rows one to five carry pixels in every digit.
    localparam logic signed [8:0] G_MIN_S    = -9'sd1;
    localparam logic signed [8:0] G_MAX_S    = 9'(IMG_HEIGHT - GLYPH_HEIGHT + 1);

    // Configuration registers.
    logic [6:0]        bw_reg;
    logic [5:0]        max_reg;
    logic signed [5:0] min_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bw_reg  <= 7'd10;
            max_reg <= 6'd32;
            min_reg <= -6'sd31;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_BAR_WIDTH: bw_reg  <= cfg_wr_data;
                CFG_MAX_VALUE: max_reg <= cfg_wr_data[5:0];
                CFG_MIN_VALUE: min_reg <= cfg_wr_data[5:0];
                default: ;
            endcase
        end
    end

    // Captured command.
    func_t             func_reg;
    logic [6:0]        px_reg;
    logic [5:0]        py_reg;
    logic signed [7:0] gv_reg;
    logic              fb_reg;
    logic [7:0]        wi_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg <= func_t'(func);
            px_reg   <= pix_x;
            py_reg   <= pix_y;
            gv_reg   <= gauge_value;
            fb_reg   <= fill_bit;
            wi_reg   <= word_index;
        end
    end

    // Sweep counter.
    logic [CNT_W-1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.capture || cmd.gauge_setup) begin
            cnt_reg <= '0;
        end else if (cmd.clear_sweep || cmd.fill_sweep || cmd.gauge_sweep) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Gauge setup: clamp, bar span, glyph row, digits and range flag.
    logic signed [8:0] v0, v1, v2, mx, mn, e, lo, hi, g, nv;
    logic [5:0]        a;
    logic [3:0]        tens;
    logic [5:0]        t10, ones_w;
    logic              gerr;

    always_comb begin
        v0 = {gv_reg[7], gv_reg};
        mx = {3'b000, max_reg};
        mn = {{3{min_reg[5]}}, min_reg};
        v1 = (v0 > mx) ? mx : v0;
        v2 = (v1 < mn) ? mn : v1;
        e  = MID_S - v2;
        lo = (e < MID_S) ? e : MID_S;
        hi = (e < MID_S) ? MID_S : e;
        if (e > MID_S - GH_S && e <= MID_S) begin
            g = MID_S - GH_S;
        end else if (e > MID_S) begin
            g = e - GH_S;
        end else begin
            g = e;
        end
        nv = -v2;
        a  = (v2 < 0) ? nv[5:0] : v2[5:0];
        if      (a >= 6'd60) tens = 4'd6;
        else if (a >= 6'd50) tens = 4'd5;
        else if (a >= 6'd40) tens = 4'd4;
        else if (a >= 6'd30) tens = 4'd3;
        else if (a >= 6'd20) tens = 4'd2;
        else if (a >= 6'd10) tens = 4'd1;
        else                 tens = 4'd0;
        t10    = {2'b00, tens} * 6'd10;
        ones_w = a - t10;
        gerr   = (({1'b0, bw_reg} + 8'd1) == 8'(IMG_WIDTH))
               || ((bw_reg != 7'd0) && ((lo < 0) || (hi > LAST_ROW_S)))
               || (g < G_MIN_S) || (g > G_MAX_S);
    end

    logic signed [8:0] lo_reg, hi_reg, g_reg;
    logic [3:0]        tens_reg, ones_reg;
    logic              gerr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.gauge_setup) begin
            lo_reg   <= lo;
            hi_reg   <= hi;
            g_reg    <= g;
            tens_reg <= tens;
            ones_reg <= ones_w[3:0];
            gerr_reg <= gerr;
        end
    end

    // Framebuffer memory with registered read.
    logic [31:0]       mem [FRAME_WORDS];
    logic [31:0]       rdata_reg;
    logic              we, re;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [31:0]       wdata;

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (re) rdata_reg <= mem[raddr];
    end

    // New value of one framebuffer word during the gauge sweep.
    logic [ADDR_W-1:0] wa;
    logic [5:0]        gy;
    logic [1:0]        gk;
    logic signed [8:0] ys, gr;
    logic              in_bar, g_act;
    logic [6:0]        col;
    logic [7:0]        bwp1;
    logic [31:0]       clr, colm, gmask, gword;

    always_comb begin
        wa     = ADDR_W'(cnt_reg - 1'b1);
        gy     = wa[7:2];
        gk     = wa[1:0];
        ys     = {3'b000, gy};
        in_bar = (ys >= lo_reg) && (ys <= hi_reg);
        gr     = ys - g_reg;
        g_act  = (gk == 2'd0) && (gr >= 0) && (gr < GH_S);
        bwp1   = {1'b0, bw_reg} + 8'd1;
        for (int j = 0; j < WORD_BITS; j++) begin
            col            = {gk, 5'(j)};
            clr[31 - j]    = col < bw_reg;
            colm[31 - j]   = {1'b0, col} == bwp1;
        end
        gmask = g_act ? {glyph_row(tens_reg, gr[2:0]), glyph_row(ones_reg, gr[2:0]), 22'd0}
                      : 32'd0;
        gword = ((rdata_reg & ~clr) | (in_bar ? clr : 32'd0) | colm) ^ gmask;
    end

    // Single pixel update.
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pmask, pword;

    always_comb begin
        paddr = {py_reg, px_reg[6:5]};
        pmask = 32'h8000_0000 >> px_reg[4:0];
        case (func_reg)
            FN_SET:    pword = rdata_reg | pmask;
            FN_CLEAR:  pword = rdata_reg & ~pmask;
            FN_TOGGLE: pword = rdata_reg ^ pmask;
            default:   pword = rdata_reg;
        endcase
    end

    // Memory port selection.
    always_comb begin
        we    = 1'b0;
        re    = 1'b0;
        waddr = cnt_reg[ADDR_W-1:0];
        raddr = cnt_reg[ADDR_W-1:0];
        wdata = 32'd0;
        if (cmd.clear_sweep) begin
            we = 1'b1;
        end
        if (cmd.fill_sweep) begin
            we    = 1'b1;
            wdata = {32{fb_reg}};
        end
        if (cmd.pix_rd) begin
            re    = 1'b1;
            raddr = (func_reg == FN_READ_WORD) ? wi_reg : paddr;
        end
        if (cmd.pix_wr) begin
            we    = (func_reg == FN_SET) || (func_reg == FN_CLEAR) || (func_reg == FN_TOGGLE);
            waddr = paddr;
            wdata = pword;
        end
        if (cmd.gauge_sweep) begin
            re    = !cnt_reg[ADDR_W];
            we    = cnt_reg != '0;
            waddr = wa;
            wdata = gword;
        end
    end

    // Result registers.
    logic        pbit_reg, rerr_reg;
    logic [31:0] wd_reg;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            pbit_reg <= (func_reg == FN_READ_PIX) && rdata_reg[~px_reg[4:0]];
            wd_reg   <= (func_reg == FN_READ_WORD) ? rdata_reg : 32'd0;
            rerr_reg <= (func_reg == FN_GAUGE) && gerr_reg;
        end
    end

    assign pixel_bit   = pbit_reg;
    assign word_data   = wd_reg;
    assign range_error = rerr_reg;

    assign status.func       = func_reg;
    assign status.sweep_last = cnt_reg[ADDR_W-1:0] == {ADDR_W{1'b1}};
    assign status.gauge_last = cnt_reg[ADDR_W];

endmodule

### sv/bitmap_bar_gauge_renderer.sv
// Bar gauge renderer over a 128 x 64 one-bit framebuffer held in 256 words of 32 bits,
// leftmost pixel in the word's high bit. Commands arrive one at a time and each gives
// one result. The steps of a command, from the accepting cycle up to the cycle that
// loads the result, are set by the single-port-pair framebuffer memory: set, clear,
// toggle, read pixel and read word go through accept, decode, read, modify and write,
// and result; fill through accept, decode, one word per cycle, and result; draw gauge
// through accept, decode, setup, a read-modify-write of every word pipelined at one
// word per cycle, and result; an unused command through accept, decode and result.
// A result that is not taken holds the next command in its result cycle. After reset
// the block clears the framebuffer in one pass and takes no command meanwhile;
// configuration writes are taken at any time but must only be issued while no command
// is in progress.
module bitmap_bar_gauge_renderer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: pix_x[6:0], pix_y[12:7], gauge_value[20:13], fill_bit[21],
    //          word_index[29:22], zero fill[31:30]
    input  logic [31:0] s_tdata,
    // s_tuser: func[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: pixel_bit[0], word_data[32:1], range_error[33], zero fill[39:34]
    output logic [39:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_index,
    input  logic [6:0]  cfg_wr_data
);
    import bbgr_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       pixel_bit, range_error;
    logic [31:0] word_data;

    bbgr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bbgr_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .func         (s_tuser),
        .pix_x        (s_tdata[6:0]),
        .pix_y        (s_tdata[12:7]),
        .gauge_value  (s_tdata[20:13]),
        .fill_bit     (s_tdata[21]),
        .word_index   (s_tdata[29:22]),
        .pixel_bit    (pixel_bit),
        .word_data    (word_data),
        .range_error  (range_error)
    );

    assign m_tdata = {6'd0, range_error, word_data, pixel_bit};

    // A command transfer is followed by a busy period.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a command is in progress");

    // A result only appears once the command has left the idle state.
    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised without a command in progress");

    // A range error only comes from a gauge draw, which returns no read data.
    a_error_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[33]) |-> (m_tdata[32:0] == 33'd0))
        else $error("range error together with read data");

endmodule

### bench/bitmap_bar_gauge_renderer_check.sv
`timescale 1ns / 100ps

module bitmap_bar_gauge_renderer_check
    import bbgr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_index,
    input  logic [6:0]  cfg_wr_data,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic        range_error;
        logic [31:0] word_data;
        logic        pixel_bit;
    } reply_t;

    typedef enum int { PX_SET, PX_CLEAR, PX_TOGGLE } pix_op_t;

    // Shadow image and register copies.
    logic [31:0] shadow_frame [FRAME_WORDS];
    logic [6:0]  bar_w;
    logic [5:0]  max_lim;
    logic [5:0]  min_lim;
    logic        shadow_range;
    reply_t      expected_replies [$];

    // Apply one pixel operation, flagging coordinates off the image.
    function automatic void touch_pixel(int x, int y, pix_op_t op);
        int off;
        int bitpos;
        if (x < 0 || y < 0 || x >= IMG_WIDTH || y >= IMG_HEIGHT) begin
            shadow_range = 1'b1;
            return;
        end
        off = y * IMG_WIDTH + x;
        bitpos = 31 - (off % 32);
        case (op)
            PX_SET:   shadow_frame[off / 32][bitpos] = 1'b1;
            PX_CLEAR: shadow_frame[off / 32][bitpos] = 1'b0;
            default:  shadow_frame[off / 32][bitpos] = ~shadow_frame[off / 32][bitpos];
        endcase
    endfunction

    function automatic void toggle_digit(int x0, int y0, int digit);
        logic [34:0] gw;
        gw = GLYPH_ROM[digit];
        for (int r = 0; r < GLYPH_HEIGHT; r++)
            for (int c = 0; c < GLYPH_WIDTH; c++)
                if (gw[34 - (r * GLYPH_WIDTH + c)])
                    touch_pixel(x0 + c, y0 + r, PX_TOGGLE);
    endfunction

    // Redraw the bar area, the bar and the two digits for one gauge value.
    function automatic void draw_bar(logic signed [7:0] gval);
        int v;
        int bw;
        int e;
        int lo;
        int hi;
        int g;
        int a;
        v = gval;
        bw = bar_w;
        if (v > int'(max_lim)) v = max_lim;
        if (v < int'($signed(min_lim))) v = $signed(min_lim);
        for (int y = 0; y < IMG_HEIGHT; y++)
            touch_pixel(bw + 1, y, PX_SET);
        for (int x = 0; x < bw; x++)
            for (int y = 0; y < IMG_HEIGHT; y++)
                touch_pixel(x, y, PX_CLEAR);
        e = MID_ROW - v;
        lo = (e < MID_ROW) ? e : MID_ROW;
        hi = (e < MID_ROW) ? MID_ROW : e;
        for (int x = 0; x < bw; x++)
            for (int y = lo; y <= hi; y++)
                touch_pixel(x, y, PX_SET);
        a = (v < 0) ? -v : v;
        g = e;
        if (g > MID_ROW - GLYPH_HEIGHT && g <= MID_ROW)
            g = MID_ROW - GLYPH_HEIGHT;
        else if (g > MID_ROW)
            g = g - GLYPH_HEIGHT;
        toggle_digit(0, g, (a / 10) % 10);
        toggle_digit(GLYPH_WIDTH, g, a % 10);
    endfunction

    // Work out the reply to one command and update the shadow image.
    function automatic reply_t render_command(func_t fn, logic [31:0] d);
        reply_t rep;
        int px;
        int py;
        int wi;
        px = d[6:0];
        py = d[12:7];
        wi = d[29:22];
        rep = '0;
        shadow_range = 1'b0;
        case (fn)
            FN_FILL: begin
                for (int i = 0; i < FRAME_WORDS; i++)
                    shadow_frame[i] = {32{d[21]}};
            end
            FN_SET:    touch_pixel(px, py, PX_SET);
            FN_CLEAR:  touch_pixel(px, py, PX_CLEAR);
            FN_TOGGLE: touch_pixel(px, py, PX_TOGGLE);
            FN_READ_PIX: begin
                if (px < IMG_WIDTH && py < IMG_HEIGHT)
                    rep.pixel_bit = shadow_frame[(py * IMG_WIDTH + px) / 32]
                                                [31 - ((py * IMG_WIDTH + px) % 32)];
                else
                    shadow_range = 1'b1;
            end
            FN_GAUGE: draw_bar(d[20:13]);
            FN_READ_WORD: begin
                if (wi < FRAME_WORDS)
                    rep.word_data = shadow_frame[wi];
            end
            default: ;
        endcase
        rep.range_error = shadow_range;
        return rep;
    endfunction

    assign pending = expected_replies.size();

    // Follow register writes, command transfers and result transfers.
    always @(posedge aclk) begin
        reply_t exp_r;
        reply_t got;
        if (!aresetn) begin
            for (int i = 0; i < FRAME_WORDS; i++)
                shadow_frame[i] = '0;
            bar_w = 7'd10;
            max_lim = 6'd32;
            min_lim = 6'h21;
            expected_replies.delete();
            fail_count <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    CFG_BAR_WIDTH: bar_w = cfg_wr_data;
                    CFG_MAX_VALUE: max_lim = cfg_wr_data[5:0];
                    CFG_MIN_VALUE: min_lim = cfg_wr_data[5:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[33:0];
                if (expected_replies.size() == 0) begin
                    if (fail_count < 10)
                        $display("Unexpected result transfer: %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = expected_replies.pop_front();
                    if (got !== exp_r || m_tdata[39:34] !== '0) begin
                        if (fail_count < 10)
                            $display("Mismatch: pixel %b/%b word %h/%h range %b/%b (exp/act)",
                                     exp_r.pixel_bit, got.pixel_bit, exp_r.word_data,
                                     got.word_data, exp_r.range_error, got.range_error);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_replies.push_back(render_command(func_t'(s_tuser), s_tdata));
        end
    end

endmodule

### bench/bitmap_bar_gauge_renderer_tb.sv
`timescale 1ns / 100ps

module bitmap_bar_gauge_renderer_tb;
    import bbgr_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_wr_index = '0;
    logic [6:0]  cfg_wr_data = '0;
    int          fail_count;
    int          pending;

    int send_idle = 31;
    int recv_idle = 63;
    int phase = 0;
    int hold_left = 0;
    bit held = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    bitmap_bar_gauge_renderer dut (.*);

    bitmap_bar_gauge_renderer_check checker_i (.*);

    // Receiver: random back-pressure, plus one long hold-off in the last phase.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (phase == 5 && !held) begin
            held <= 1'b1;
            hold_left <= 600;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // One command transfer, with random idle cycles ahead of it.
    task automatic send_cmd(func_t fn, logic [6:0] px, logic [5:0] py, logic [7:0] gv,
                            logic fb, logic [7:0] wi);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= fn;
        s_tdata <= {2'b00, wi, fb, gv, py, px};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] val);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Random command mix; reads dominate so drawn images get observed.
    task automatic random_cmd();
        int pick;
        func_t fn;
        pick = $urandom_range(99);
        if (pick < 8) fn = FN_GAUGE;
        else if (pick < 10) fn = FN_FILL;
        else if (pick < 12) fn = FN_NONE;
        else if (pick < 45) fn = FN_READ_WORD;
        else if (pick < 60) fn = FN_READ_PIX;
        else fn = func_t'($urandom_range(1, 3));
        send_cmd(fn, 7'($urandom_range(127)), 6'($urandom_range(63)),
                 8'($urandom_range(255)), 1'($urandom_range(1)), 8'($urandom_range(255)));
    endtask

    initial begin
        int unused;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed commands at the field extremes.
        send_cmd(FN_READ_WORD, 0, 0, 0, 0, 8'd255);
        send_cmd(FN_FILL, 0, 0, 0, 1'b1, 0);
        send_cmd(FN_READ_WORD, 0, 0, 0, 0, 8'd0);
        send_cmd(FN_READ_PIX, 7'd127, 6'd63, 0, 0, 0);
        send_cmd(FN_CLEAR, 7'd127, 6'd63, 0, 0, 0);
        send_cmd(FN_READ_WORD, 0, 0, 0, 0, 8'd255);
        send_cmd(FN_FILL, 0, 0, 0, 1'b0, 0);
        send_cmd(FN_SET, 7'd0, 6'd0, 0, 0, 0);
        send_cmd(FN_TOGGLE, 7'd127, 6'd0, 0, 0, 0);
        send_cmd(FN_TOGGLE, 7'd0, 6'd0, 0, 0, 0);
        send_cmd(FN_READ_WORD, 0, 0, 0, 0, 8'd0);
        send_cmd(FN_READ_WORD, 0, 0, 0, 0, 8'd3);
        send_cmd(FN_READ_PIX, 7'd127, 6'd0, 0, 0, 0);
        send_cmd(FN_GAUGE, 0, 0, 8'h7F, 0, 0);
        send_cmd(FN_READ_WORD, 0, 0, 0, 0, 8'd0);
        send_cmd(FN_GAUGE, 0, 0, 8'h80, 0, 0);
        send_cmd(FN_READ_WORD, 0, 0, 0, 0, 8'd252);
        send_cmd(FN_GAUGE, 0, 0, 8'd0, 0, 0);
        send_cmd(FN_GAUGE, 0, 0, 8'd29, 0, 0);
        send_cmd(FN_READ_WORD, 0, 0, 0, 0, 8'd4);
        send_cmd(FN_GAUGE, 0, 0, 8'hF7, 0, 0);
        send_cmd(FN_READ_WORD, 0, 0, 0, 0, 8'd160);
        send_cmd(FN_NONE, 7'd127, 6'd63, 8'hFF, 1'b1, 8'hFF);

        // Phases: registers change between them, idling changes every two.
        for (int p = 0; p < 6; p++) begin
            wait_drained();
            phase = p;
            case (p)
                1: begin
                    write_reg(CFG_BAR_WIDTH, 7'd1);
                    write_reg(CFG_MAX_VALUE, 7'd0);
                    write_reg(CFG_MIN_VALUE, 7'd0);
                end
                2: begin
                    write_reg(CFG_BAR_WIDTH, 7'd126);
                    write_reg(CFG_MAX_VALUE, 7'd32);
                    write_reg(CFG_MIN_VALUE, 7'h21);
                end
                3, 4, 5: begin
                    write_reg(CFG_BAR_WIDTH, 7'($urandom_range(1, 126)));
                    write_reg(CFG_MAX_VALUE, 7'($urandom_range(0, 32)));
                    unused = $urandom_range(0, 31);
                    write_reg(CFG_MIN_VALUE, 7'((64 - unused) % 64));
                end
                default: ;
            endcase
            send_idle = (p < 2) ? 31 : (p < 4) ? 63 : 0;
            recv_idle = (p < 2) ? 63 : (p < 4) ? 31 : 0;
            for (int i = 0; i < 255; i++) begin
                random_cmd();
                if (i % 60 == 59) begin
                    // Let the result stream drain before going on.
                    s_tvalid <= 1'b0;
                    @(negedge aclk);
                    while (pending != 0) @(negedge aclk);
                end
            end
        end

        wait_drained();
        repeat (300) @(negedge aclk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #40ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
